>>> hdl/vptw_pkg.sv
// ============================================================================
// vptw_pkg - shared types and constants of the vertex projection unit
// Holds the item kinds, the sequencer states and the register addresses.
// ============================================================================
package vptw_pkg;

    typedef enum logic
    {
        FUNC_LOAD    = 1'b0,
        FUNC_PROJECT = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_WIDTH    = 2'd2,
        REG_HEIGHT   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_EYE,
        ST_CLIP,
        ST_CHECK,
        ST_DIV,
        ST_NEXTQ,
        ST_WIN_X,
        ST_WIN_Y,
        ST_WIN_Z,
        ST_OUT
    } state_t;

    localparam int unsigned MODELVIEW_BASE  = 0;
    localparam int unsigned PROJECTION_BASE = 16;

endpackage

>>> hdl/vertex_project_to_window_unit.sv
// ============================================================================
// vertex_project_to_window_unit - fixed-point point projection to the window
// Keeps two column-major 4x4 matrices in a 32-word coefficient memory and
// projects object points through them into viewport coordinates.
// ============================================================================
//
//  channel   | direction | handshake              | content
//  s_axis    | in        | tvalid/tready          | load item or project item
//  m_axis    | out       | tvalid/tready          | window x, y, z and valid flag
//  apb       | in        | psel/penable/pwrite    | viewport origin and size
//
// A load item is written into the coefficient memory at its accepting edge. A project
// item runs from its accepting edge to m_axis_tvalid through seven matrix rows
// (four terms of a memory read and a multiply-add, then a store of the row), the
// clip w check, three divisions (start, 48 bit-serial steps, done), three
// viewport steps and one output step; with clip w zero it skips divisions and viewport.
// While a result waits on m_axis the next item is not accepted. Reset clears the
// control state and origin, sets the size to 640x480; coefficient memory is undefined.
//
module vertex_project_to_window_unit #(
    parameter int FRACTION_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: coef_index[4:0], coef_value[36:5], obj_x[68:37], obj_y[100:69],
    // obj_z[132:101], zero fill up to bit 135
    input  logic [135:0] s_axis_tdata,
    // tuser: func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: win_x[31:0], win_y[63:32], win_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // tuser: valid_res
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vptw_pkg::*;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRACTION_BITS;

    // Configuration registers.
    logic signed [15:0] org_x_reg, org_y_reg;
    logic [14:0]        width_reg, height_reg;
    reg_idx_t           cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            width_reg  <= 15'd640;
            height_reg <= 15'd480;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ORIGIN_X: org_x_reg  <= pwdata[15:0];
                REG_ORIGIN_Y: org_y_reg  <= pwdata[15:0];
                REG_WIDTH:    width_reg  <= pwdata[14:0];
                REG_HEIGHT:   height_reg <= pwdata[14:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ORIGIN_X: prdata = 32'($unsigned(org_x_reg));
            REG_ORIGIN_Y: prdata = 32'($unsigned(org_y_reg));
            REG_WIDTH:    prdata = {17'd0, width_reg};
            REG_HEIGHT:   prdata = {17'd0, height_reg};
            default:      prdata = '0;
        endcase
    end

    // Input fields.
    logic               in_acc;
    logic [4:0]         in_idx;
    logic [31:0]        in_coef;
    logic signed [31:0] in_x, in_y, in_z;
    assign in_idx  = s_axis_tdata[4:0];
    assign in_coef = s_axis_tdata[36:5];
    assign in_x    = s_axis_tdata[68:37];
    assign in_y    = s_axis_tdata[100:69];
    assign in_z    = s_axis_tdata[132:101];

    // Coefficient memory, synchronous read.
    logic [31:0] coef_mem [32];
    logic [31:0] rd_data_reg;
    logic [4:0]  rd_addr;

    always_ff @(posedge clk)
    begin
        if (in_acc && func_t'(s_axis_tuser) == FUNC_LOAD)
            coef_mem[in_idx] <= in_coef;
        rd_data_reg <= coef_mem[rd_addr];
    end

    // Sequencer registers.
    state_t             state_reg, state_next;
    logic [1:0]         row_reg, row_next;     // output row
    logic [2:0]         k_reg, k_next;         // term counter, 4 = drain
    logic               ph_reg, ph_next;       // 0 = issue read, 1 = multiply
    logic signed [31:0] vec_reg [4];           // input vector of the current pass
    logic signed [31:0] eye_reg [4];
    logic signed [31:0] clip_reg [3];
    logic signed [31:0] q_reg [3];
    logic signed [63:0] acc_reg;
    logic signed [31:0] cw_reg;
    logic [95:0]        out_data_reg;
    logic               out_user_reg;
    logic               out_valid_reg;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quo;

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Read address for the term being fetched.
    always_comb
    begin
        if (state_reg == ST_CLIP)
            rd_addr = 5'(PROJECTION_BASE) + {1'b0, k_reg[1:0], row_reg};
        else
            rd_addr = 5'(MODELVIEW_BASE) + {1'b0, k_reg[1:0], row_reg};
    end

    // Shared multiplier: one product, then shift and accumulate. The sum of four
    // shifted products needs far more than 32 bits before it is saturated.
    logic signed [63:0] prod;
    logic signed [31:0] vterm;
    logic signed [63:0] acc_add;
    logic signed [31:0] acc_sat;
    always_comb
    begin
        vterm   = vec_reg[k_reg[1:0]];
        prod    = $signed(rd_data_reg) * vterm;
        acc_add = acc_reg + (prod >>> FRACTION_BITS);
        if (acc_reg > 64'sh07fffffff)
            acc_sat = 32'sh7fffffff;
        else if (acc_reg < -64'sh080000000)
            acc_sat = 32'sh80000000;
        else
            acc_sat = acc_reg[31:0];
    end

    // Viewport mapping.
    logic signed [63:0] wq;
    logic signed [63:0] wt;
    logic signed [63:0] wsum;
    logic signed [31:0] wsat;
    logic signed [15:0] worg;
    logic [14:0]        wsize;
    always_comb
    begin
        worg  = (state_reg == ST_WIN_Y) ? org_y_reg : org_x_reg;
        wsize = (state_reg == ST_WIN_Y) ? height_reg : width_reg;
        wq    = 64'(q_reg[(state_reg == ST_WIN_Y) ? 2'd1 : 2'd0]) + ONE;
        wt    = (wq * $signed({1'b0, wsize})) >>> 1;
        wsum  = wt + (64'(worg) <<< FRACTION_BITS);
        if (state_reg == ST_WIN_Z)
            wsum = (64'(q_reg[2]) + ONE) >>> 1;
        if (wsum > 64'sh07fffffff)
            wsat = 32'sh7fffffff;
        else if (wsum < -64'sh080000000)
            wsat = 32'sh80000000;
        else
            wsat = wsum[31:0];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && func_t'(s_axis_tuser) == FUNC_PROJECT)
                    state_next = ST_EYE;
            ST_EYE:
                if (ph_reg && k_reg == 3'd4 && row_reg == 2'd3)
                    state_next = ST_CLIP;
            ST_CLIP:
                if (ph_reg && k_reg == 3'd4 && row_reg == 2'd2)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = (cw_reg == 32'sd0) ? ST_OUT : ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = (row_reg == 2'd2) ? ST_WIN_X : ST_NEXTQ;
            ST_NEXTQ:
                state_next = ST_DIV;
            ST_WIN_X:
                state_next = ST_WIN_Y;
            ST_WIN_Y:
                state_next = ST_WIN_Z;
            ST_WIN_Z:
                state_next = ST_OUT;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Counter and divider start logic.
    always_comb
    begin
        row_next  = row_reg;
        k_next    = k_reg;
        ph_next   = ph_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                row_next = '0;
                k_next   = '0;
                ph_next  = 1'b0;
            end
            ST_EYE, ST_CLIP:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (k_reg == 3'd4)
                    begin
                        k_next   = '0;
                        row_next = (state_next != state_reg) ? 2'd0 : row_reg + 2'd1;
                    end
                    else
                        k_next = k_reg + 3'd1;
                end
            end
            ST_CHECK:
            begin
                row_next  = '0;
                div_start = (cw_reg != 32'sd0);
            end
            ST_NEXTQ:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
                if (div_done)
                    row_next = row_reg + 2'd1;
            default: ;
        endcase
    end

    vptw_divider #(
        .FRAC(FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (clip_reg[row_reg]),
        .den   (cw_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            k_reg         <= '0;
            ph_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                vec_reg[0] <= in_x;
                vec_reg[1] <= in_y;
                vec_reg[2] <= in_z;
                vec_reg[3] <= 32'(ONE);
                acc_reg    <= '0;
            end
            ST_EYE, ST_CLIP:
            begin
                if (ph_reg)
                begin
                    if (k_reg == 3'd4)
                    begin
                        if (state_reg == ST_EYE)
                            eye_reg[row_reg] <= acc_sat;
                        else
                            clip_reg[row_reg] <= acc_sat;
                        acc_reg <= '0;
                        if (state_reg == ST_EYE && row_reg == 2'd3)
                        begin
                            vec_reg[0] <= eye_reg[0];
                            vec_reg[1] <= eye_reg[1];
                            vec_reg[2] <= eye_reg[2];
                            vec_reg[3] <= acc_sat;
                            cw_reg     <= (eye_reg[2] == 32'sh80000000) ? 32'sh7fffffff
                                                                       : 32'(-eye_reg[2]);
                        end
                    end
                    else
                        acc_reg <= acc_add;
                end
            end
            ST_DIV:
                if (div_done)
                    q_reg[row_reg] <= div_quo;
            ST_WIN_X: out_data_reg[31:0]  <= wsat;
            ST_WIN_Y: out_data_reg[63:32] <= wsat;
            ST_WIN_Z:
            begin
                out_data_reg[95:64] <= wsat;
                out_user_reg        <= 1'b1;
            end
            ST_CHECK:
                if (cw_reg == 32'sd0)
                begin
                    out_data_reg <= '0;
                    out_user_reg <= 1'b0;
                end
            default: ;
        endcase
    end

endmodule

>>> hdl/vptw_divider.sv
// ============================================================================
// vptw_divider - restoring signed divider
// Computes (num * 2^FRAC) / den truncated toward zero, one bit per cycle,
// and saturates the quotient to 32 bits.
// ============================================================================
module vptw_divider #(
    parameter int FRAC = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    localparam int NW = 32 + FRAC;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [NW-1:0] num_abs;
    logic [32:0]   shifted;
    logic [33:0]   diff;
    logic [NW:0]   qs;
    logic [NW:0]   lim;

    always_comb
    begin
        num_abs = num[31] ? NW'(-(NW'($signed(num)) <<< FRAC)) : NW'(NW'(num) << FRAC);
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], dvd_reg[NW-1]};
        diff      = {1'b0, shifted} - {2'b0, dvs_reg};
        if (start)
        begin
            dvd_next  = num_abs;
            dvs_next  = den[31] ? 32'(-den) : 32'(den);
            neg_next  = num[31] ^ den[31];
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Saturate the signed magnitude into a 32-bit word.
    always_comb
    begin
        qs  = {1'b0, q_reg};
        lim = neg_reg ? (NW+1)'(33'h080000000) : (NW+1)'(33'h07fffffff);
        if (qs > lim)
            quo = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
        else
            quo = neg_reg ? 32'(-qs) : 32'(qs);
    end

    assign done = done_reg;

endmodule

>>> verif/tb_vertex_project_to_window_unit.sv
// ============================================================================
// tb_vertex_project_to_window_unit - self-checking bench of the projection unit
// Loads coefficient matrices, projects points under several viewport settings
// and compares every window result with a fixed-point predictor or, for one directed row, a typed-in result.
// ============================================================================
module tb_vertex_project_to_window_unit;

    import vptw_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        func_t       func;
        logic [4:0]  idx;
        logic [31:0] coef;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
    } vertex_item_t;

    typedef struct {
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
        logic        ok;
    } window_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    vertex_project_to_window_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: its own copy of the coefficient memory and viewport.
    logic [31:0] coef_mem [32];
    logic [15:0] org_x, org_y;
    logic [14:0] vp_w, vp_h;

    window_result_t window_queue[$];
    int errors = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit feeding_done = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // The >>> on a signed longint floors toward minus infinity, as the block does.
    function automatic longint matrix_row(int base, int r, longint v[4]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += (longint'($signed(coef_mem[base + 4 * k + r])) * v[k]) >>> FRAC;
        return clamp32(acc);
    endfunction

    function automatic window_result_t project_point(vertex_item_t it);
        window_result_t res;
        longint obj[4], eye[4], clip[3], q[3], cw;
        obj[0] = longint'($signed(it.ox));
        obj[1] = longint'($signed(it.oy));
        obj[2] = longint'($signed(it.oz));
        obj[3] = ONE;
        for (int r = 0; r < 4; r++)
            eye[r] = matrix_row(MODELVIEW_BASE, r, obj);
        for (int r = 0; r < 3; r++)
            clip[r] = matrix_row(PROJECTION_BASE, r, eye);
        cw = clamp32(-eye[2]);
        if (cw == 0)
        begin
            res = '{32'd0, 32'd0, 32'd0, 1'b0};
            return res;
        end
        // SystemVerilog division truncates toward zero.
        for (int r = 0; r < 3; r++)
            q[r] = clamp32((clip[r] * ONE) / cw);
        res.wx = 32'(clamp32((((q[0] + ONE) * longint'(vp_w)) >>> 1)
                             + longint'($signed(org_x)) * ONE));
        res.wy = 32'(clamp32((((q[1] + ONE) * longint'(vp_h)) >>> 1)
                             + longint'($signed(org_y)) * ONE));
        res.wz = 32'(clamp32((q[2] + ONE) >>> 1));
        res.ok = 1'b1;
        return res;
    endfunction

    // Result side: random stalls, compare against the oldest expectation.
    initial
    begin
        window_result_t exp_r;
        window_result_t got;
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // Some stretches run without any stall.
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got.wx = m_axis_tdata[31:0];
            got.wy = m_axis_tdata[63:32];
            got.wz = m_axis_tdata[95:64];
            got.ok = m_axis_tuser;
            results_seen++;
            if (window_queue.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h z=%h v=%b", $time,
                         got.wx, got.wy, got.wz, got.ok);
                errors++;
            end
            else
            begin
                exp_r = window_queue.pop_front();
                if (got.wx !== exp_r.wx)
                begin
                    $display("%0t: win_x expected %h actual %h", $time, exp_r.wx, got.wx);
                    errors++;
                end
                if (got.wy !== exp_r.wy)
                begin
                    $display("%0t: win_y expected %h actual %h", $time, exp_r.wy, got.wy);
                    errors++;
                end
                if (got.wz !== exp_r.wz)
                begin
                    $display("%0t: win_z expected %h actual %h", $time, exp_r.wz, got.wz);
                    errors++;
                end
                if (got.ok !== exp_r.ok)
                begin
                    $display("%0t: valid_res expected %b actual %b", $time, exp_r.ok, got.ok);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side accepts an item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || feeding_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle; pready is always high.
    // The bus is then left idle before the task returns, so that back-to-back writes
    // drive each signal once per clock edge.
    task automatic write_register(reg_idx_t r, logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 4'(r) << 2;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_ORIGIN_X: org_x = v[15:0];
            REG_ORIGIN_Y: org_y = v[15:0];
            REG_WIDTH:    vp_w  = v[14:0];
            REG_HEIGHT:   vp_h  = v[14:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    // Sends one item, with a random gap before it unless no_gap is set, and records
    // its expectation. tvalid stays high after the accepting edge until the next item
    // or an idle period drops it, so that it is driven only once per clock edge.
    task automatic send_item(vertex_item_t it, bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {3'b000, it.oz, it.oy, it.ox, it.coef, it.idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (it.func == FUNC_LOAD)
            coef_mem[it.idx] = it.coef;
        else
            window_queue.push_back(project_point(it));
    endtask

    task automatic load_coef(int slot, logic [31:0] v);
        vertex_item_t it;
        it = '{FUNC_LOAD, 5'(slot), v, $urandom, $urandom, $urandom};
        send_item(it, 1'b0);
    endtask

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vertex_item_t it;
        it = '{FUNC_PROJECT, 5'($urandom), $urandom, x, y, z};
        send_item(it, 1'b0);
    endtask

    // Stop feeding, wait for all results, then leave some idle cycles.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (window_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Mostly small coefficients so results stay in range; some full range.
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 65536 * 4)) - 65536 * 2);
            2:       return 32'h0;
            default: return 32'($signed($urandom_range(0, 65536 * 16)) - 65536 * 8);
        endcase
    endfunction

    function automatic logic [31:0] rand_point();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            default: return 32'($signed($urandom_range(0, 65536 * 200)) - 65536 * 100);
        endcase
    endfunction

    // Directed rows: the identity modelview with a simple perspective matrix,
    // then points at the field extremes and a point on the eye plane (clip w
    // zero). The clip-w-zero row has its result typed in.
    typedef struct {
        logic [31:0] x, y, z;
        bit          known;
        window_result_t res;
    } directed_row_t;

    directed_row_t directed_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_0000, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{32'h0010_0000, 32'hFFF0_0000, 32'hFFFF_8000, 1'b0, '{32'd0, 32'd0, 32'd0, 1'b0}}
    };

    // Viewport settings walked by the phases, extremes included.
    logic [31:0] setting_ox[] = '{32'h0, 32'h7FFF, 32'hFFFF_8000, 32'h0000_0040, 32'hFFFF_FFF0};
    logic [31:0] setting_oy[] = '{32'h0, 32'hFFFF_8000, 32'h7FFF, 32'h0000_0020, 32'h0000_1234};
    logic [31:0] setting_w[]  = '{32'd640, 32'd0, 32'd32767, 32'd1920, 32'd7};
    logic [31:0] setting_h[]  = '{32'd480, 32'd32767, 32'd0, 32'd1080, 32'd3};

    initial
    begin
        vertex_item_t it;
        int phase_len;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < 32; i++)
            coef_mem[i] = '0;
        org_x = 16'd0;
        org_y = 16'd0;
        vp_w = 15'd640;
        vp_h = 15'd480;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every slot is written before any project item reads it; both
        // matrices start as the identity.
        for (int s = 0; s < 32; s++)
            load_coef(s, ((s % 16) % 5 == 0) ? 32'h0001_0000 : 32'h0);
        // Projection: clip x, y taken straight from eye; twice eye w comes off z.
        load_coef(16 + 14, 32'hFFFE_0000);
        load_coef(15, 32'h8000_0000);
        load_coef(15, 32'h7FFF_FFFF);
        load_coef(15, 32'h0001_0000);

        foreach (directed_rows[i])
        begin
            send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z);
            if (directed_rows[i].known)
                window_queue[$] = directed_rows[i].res;
        end
        drain();

        // Random phases, each under its own viewport setting.
        for (int p = 0; p < setting_ox.size(); p++)
        begin
            write_register(REG_ORIGIN_X, setting_ox[p]);
            write_register(REG_ORIGIN_Y, setting_oy[p]);
            write_register(REG_WIDTH, setting_w[p]);
            write_register(REG_HEIGHT, setting_h[p]);
            phase_len = RANDOM_ITEMS / setting_ox.size();
            for (int n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                    load_coef($urandom_range(0, 31), rand_coef());
                else if ($urandom_range(0, 19) == 0)
                begin
                    // Point on the eye plane: eye z becomes exactly zero.
                    it = '{FUNC_PROJECT, 5'($urandom), $urandom, rand_point(),
                           rand_point(), 32'h0};
                    load_coef(2, 32'h0);
                    load_coef(6, 32'h0);
                    load_coef(10, 32'h0);
                    load_coef(14, 32'h0);
                    send_item(it, 1'b1);
                end
                else
                    send_vertex(rand_point(), rand_point(), rand_point());
            end
            drain();
        end

        feeding_done = 1'b1;
        $display("Covered %0d results over %0d viewport settings with random stalls.",
                 results_seen, setting_ox.size());
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
